/* rtl/vector_result_flag_unit_macros.svh */
`ifndef VECTOR_RESULT_FLAG_UNIT_MACROS_SVH
`define VECTOR_RESULT_FLAG_UNIT_MACROS_SVH

// same-cycle implication, checked only out of reset
`define VRFU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("vrfu same-cycle check failed");

// next-cycle implication, checked only out of reset
`define VRFU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("vrfu next-cycle check failed");

`endif

/* rtl/vrfu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package vrfu_pkg;

    localparam int NUM_LANES = 4;
    localparam int LANE_W    = 32;
    localparam int MAC_W     = 16;
    localparam int STAT_W    = 12;

    localparam logic [LANE_W-1:0] LANE_MAX_FINITE = 32'h7f7f_ffff;
    localparam logic [STAT_W-1:0] STAT_KEEP_MASK  = 12'hc30;

    typedef struct packed {
        logic over;
        logic under;
        logic sign;
        logic zero;
    } vrfu_flags_t;

endpackage

`default_nettype wire

/* rtl/vrfu_lane.sv */
`timescale 1ns / 1ps
`default_nettype none

module vrfu_lane
    import vrfu_pkg::*;
(
    input  wire logic [LANE_W-1:0] lane_val,
    input  wire logic              lane_wr,
    input  wire logic              old_zero,
    output logic      [LANE_W-1:0] lane_res,
    output vrfu_flags_t            lane_flags
);

    logic [7:0]  expo;
    logic [22:0] mant;
    logic        sign;

    assign expo = lane_val[30:23];
    assign mant = lane_val[22:0];
    assign sign = lane_val[31];

    always_comb begin
        lane_res   = '0;
        lane_flags = '0;
        if (lane_wr) begin
            lane_flags.sign = sign;
            if (expo == 8'h00 && mant == 23'h0) begin
                lane_flags.zero = 1'b1;
                lane_res        = lane_val;
            end else if (expo == 8'h00) begin
                // denormal flushes to signed zero
                lane_flags.zero  = 1'b1;
                lane_flags.under = 1'b1;
                lane_res         = {sign, {(LANE_W-1){1'b0}}};
            end else if (&expo) begin
                // inf or nan clamps to signed max, zero flag kept
                lane_flags.zero = old_zero;
                lane_flags.over = 1'b1;
                lane_res        = {sign, {(LANE_W-1){1'b0}}} | LANE_MAX_FINITE;
            end else begin
                lane_res = lane_val;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/vrfu_status.sv */
`timescale 1ns / 1ps
`default_nettype none

module vrfu_status
    import vrfu_pkg::*;
(
    input  wire logic [STAT_W-1:0] stat_old,
    input  wire logic [MAC_W-1:0]  mac_new,
    input  wire logic              update,
    output logic      [STAT_W-1:0] stat_new
);

    vrfu_flags_t any_flags;

    assign any_flags.zero  = |mac_new[3:0];
    assign any_flags.sign  = |mac_new[7:4];
    assign any_flags.under = |mac_new[11:8];
    assign any_flags.over  = |mac_new[15:12];

    always_comb begin
        stat_new = stat_old;
        if (update) begin
            stat_new = (stat_old & STAT_KEEP_MASK)
                     | {2'b00, stat_old[3:0], 2'b00, any_flags};
        end
    end

endmodule

`default_nettype wire

/* rtl/vector_result_flag_unit.sv */
// vector_result_flag_unit
// Input channel s_*: one four-lane result (raw single bits), a lane write
// mask (bit3 x .. bit0 w) and an update_status bit, with s_valid/s_ready.
// Result channel m_*: flushed/clamped lanes, the 16-bit mac flag word and
// the 12-bit status word after the item, with m_valid/m_ready.
// An accepted item is held in the input register, classified out of it
// combinationally and loaded into the result register that drives m_*.
// Throughput: one item per cycle while m_ready does not stall; the only
// loop is the mac/status state, which is read and written once per item.
// Reset (aresetn low, synchronous): both valid registers drop and the mac
// and status words clear to zero.
// When the receiver stalls, the result stays on m_*, one more item waits
// in the input register, and s_ready drops only when both are full.
`timescale 1ns / 1ps
`default_nettype none

`include "vector_result_flag_unit_macros.svh"

module vector_result_flag_unit
    import vrfu_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [LANE_W-1:0] s_lane_x,
    input  wire logic [LANE_W-1:0] s_lane_y,
    input  wire logic [LANE_W-1:0] s_lane_z,
    input  wire logic [LANE_W-1:0] s_lane_w,
    input  wire logic [3:0]        s_write_mask,
    input  wire logic              s_update_status,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic      [LANE_W-1:0] m_out_x,
    output logic      [LANE_W-1:0] m_out_y,
    output logic      [LANE_W-1:0] m_out_z,
    output logic      [LANE_W-1:0] m_out_w,
    output logic      [MAC_W-1:0]  m_mac_word,
    output logic      [STAT_W-1:0] m_status_word,
    output logic                   m_valid,
    input  wire logic              m_ready
);

    logic              in_valid_reg;
    logic [LANE_W-1:0] in_lane_reg [NUM_LANES];
    logic [3:0]        in_mask_reg;
    logic              in_upd_reg;

    logic              out_valid_reg;
    logic [LANE_W-1:0] out_lane_reg [NUM_LANES];
    logic [MAC_W-1:0]  mac_reg;
    logic [MAC_W-1:0]  mac_next;
    logic [STAT_W-1:0] stat_reg;
    logic [STAT_W-1:0] stat_next;

    logic [LANE_W-1:0] lane_res [NUM_LANES];
    vrfu_flags_t       lane_flags [NUM_LANES];

    logic out_load;
    logic xfer;
    logic s_take;

    // lane index follows mask bit position: 3 is x, 0 is w
    assign out_load = !out_valid_reg || m_ready;
    assign xfer     = in_valid_reg && out_load;
    assign s_ready  = !in_valid_reg || out_load;
    assign s_take   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_lane_reg[3] <= s_lane_x;
            in_lane_reg[2] <= s_lane_y;
            in_lane_reg[1] <= s_lane_z;
            in_lane_reg[0] <= s_lane_w;
            in_mask_reg    <= s_write_mask;
            in_upd_reg     <= s_update_status;
        end
    end

    for (genvar p = 0; p < NUM_LANES; p++) begin : g_lane
        vrfu_lane u_lane (
            .lane_val   (in_lane_reg[p]),
            .lane_wr    (in_mask_reg[p]),
            .old_zero   (mac_reg[p]),
            .lane_res   (lane_res[p]),
            .lane_flags (lane_flags[p])
        );
    end

    always_comb begin
        mac_next = '0;
        for (int i = 0; i < NUM_LANES; i++) begin
            mac_next[i]                 = lane_flags[i].zero;
            mac_next[NUM_LANES + i]     = lane_flags[i].sign;
            mac_next[2 * NUM_LANES + i] = lane_flags[i].under;
            mac_next[3 * NUM_LANES + i] = lane_flags[i].over;
        end
    end

    vrfu_status u_status (
        .stat_old (stat_reg),
        .mac_new  (mac_next),
        .update   (in_upd_reg),
        .stat_new (stat_next)
    );

    // flag state moves with the item into the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            mac_reg       <= '0;
            stat_reg      <= '0;
        end else begin
            if (out_load) begin
                out_valid_reg <= in_valid_reg;
            end
            if (xfer) begin
                mac_reg  <= mac_next;
                stat_reg <= stat_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (xfer) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                out_lane_reg[i] <= lane_res[i];
            end
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_out_x       = out_lane_reg[3];
    assign m_out_y       = out_lane_reg[2];
    assign m_out_z       = out_lane_reg[1];
    assign m_out_w       = out_lane_reg[0];
    assign m_mac_word    = mac_reg;
    assign m_status_word = stat_reg;

    `VRFU_ASSERT_NOW(a_under_has_zero, m_valid, (m_mac_word[11:8] & ~m_mac_word[3:0]) == 4'h0)
    `VRFU_ASSERT_NOW(a_under_over_excl, m_valid, (m_mac_word[11:8] & m_mac_word[15:12]) == 4'h0)
    `VRFU_ASSERT_NOW(a_over_x_clamped, m_valid && m_mac_word[15], m_out_x[30:0] == 31'h7f7fffff)
    `VRFU_ASSERT_NEXT(a_state_holds, !xfer, $stable(stat_reg) && $stable(mac_reg))

endmodule

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench
    import vrfu_pkg::*;
;

    localparam int STALL_LIMIT  = 4000;
    localparam int PHASE_ITEMS  = 250;
    localparam int MAX_REPORTED = 10;

    localparam logic [LANE_W-1:0] POS_ZERO     = 32'h0000_0000;
    localparam logic [LANE_W-1:0] NEG_ZERO     = 32'h8000_0000;
    localparam logic [LANE_W-1:0] MIN_DENORM   = 32'h0000_0001;
    localparam logic [LANE_W-1:0] NEG_DENORM   = 32'h807f_ffff;
    localparam logic [LANE_W-1:0] NEG_SMALL_DN = 32'h8000_0001;
    localparam logic [LANE_W-1:0] MIN_NORMAL   = 32'h0080_0000;
    localparam logic [LANE_W-1:0] POS_INF      = 32'h7f80_0000;
    localparam logic [LANE_W-1:0] NEG_INF      = 32'hff80_0000;
    localparam logic [LANE_W-1:0] QUIET_NAN    = 32'h7fc0_0001;
    localparam logic [LANE_W-1:0] ALL_ONES     = 32'hffff_ffff;
    localparam logic [LANE_W-1:0] POS_ONE      = 32'h3f80_0000;
    localparam logic [LANE_W-1:0] NEG_ONE      = 32'hbf80_0000;
    localparam logic [LANE_W-1:0] NEG_PI       = 32'hc049_0fdb;
    localparam logic [LANE_W-1:0] NEG_MAX      = 32'hff7f_ffff;

    localparam logic [3:0] MASK_NONE = 4'h0;
    localparam logic [3:0] MASK_ALL  = 4'hf;
    localparam logic [3:0] MASK_X    = 4'h8;
    localparam logic [3:0] MASK_Y    = 4'h4;
    localparam logic [3:0] MASK_Z    = 4'h2;
    localparam logic [3:0] MASK_W    = 4'h1;
    localparam logic [3:0] MASK_XZ   = 4'ha;
    localparam logic [3:0] MASK_YW   = 4'h5;

    typedef enum int {
        CLS_ZERO,
        CLS_DENORMAL,
        CLS_SATURATE,
        CLS_ANY
    } lane_class_t;

    // lanes[3] is x, lanes[0] is w, matching the mask bit order
    typedef struct packed {
        logic [NUM_LANES-1:0][LANE_W-1:0] lanes;
        logic [3:0]                       write_mask;
        logic                             update_status;
    } lane_item_t;

    typedef struct packed {
        logic [NUM_LANES-1:0][LANE_W-1:0] lanes;
        logic [MAC_W-1:0]                 mac_word;
        logic [STAT_W-1:0]                status_word;
    } flag_result_t;

    class lane_flag_tracker;
        logic [MAC_W-1:0]  mac_flags;
        logic [STAT_W-1:0] status_flags;
        flag_result_t      pending_results[$];
        int                mismatches;

        function new();
            mac_flags    = '0;
            status_flags = '0;
            mismatches   = 0;
        endfunction

        function void note_item(lane_item_t item);
            flag_result_t      r;
            logic [MAC_W-1:0]  mac;
            logic [LANE_W-1:0] v;
            logic [3:0]        nf;
            mac = mac_flags;
            for (int p = 0; p < NUM_LANES; p++) begin
                v = item.lanes[p];
                if (!item.write_mask[p]) begin
                    mac[p]      = 1'b0;
                    mac[4 + p]  = 1'b0;
                    mac[8 + p]  = 1'b0;
                    mac[12 + p] = 1'b0;
                    r.lanes[p]  = '0;
                end else begin
                    mac[4 + p] = v[31];
                    if (v[30:23] == 8'h00 && v[22:0] == 23'h0) begin
                        mac[p]      = 1'b1;
                        mac[8 + p]  = 1'b0;
                        mac[12 + p] = 1'b0;
                        r.lanes[p]  = v;
                    end else if (v[30:23] == 8'h00) begin
                        mac[p]      = 1'b1;
                        mac[8 + p]  = 1'b1;
                        mac[12 + p] = 1'b0;
                        r.lanes[p]  = {v[31], 31'b0};
                    end else if (v[30:23] == 8'hff) begin
                        // zero flag of the lane is left alone here
                        mac[8 + p]  = 1'b0;
                        mac[12 + p] = 1'b1;
                        r.lanes[p]  = {v[31], 31'b0} | LANE_MAX_FINITE;
                    end else begin
                        mac[p]      = 1'b0;
                        mac[8 + p]  = 1'b0;
                        mac[12 + p] = 1'b0;
                        r.lanes[p]  = v;
                    end
                end
            end
            mac_flags = mac;
            if (item.update_status) begin
                nf = {|mac[15:12], |mac[11:8], |mac[7:4], |mac[3:0]};
                status_flags = (status_flags & STAT_KEEP_MASK) |
                               {2'b00, status_flags[3:0], 2'b00, nf};
            end
            r.mac_word    = mac_flags;
            r.status_word = status_flags;
            pending_results.push_back(r);
        endfunction

        function void report(string field, logic [31:0] want, logic [31:0] got);
            mismatches++;
            if (mismatches <= MAX_REPORTED)
                $display("mismatch on %s: expected %h, got %h", field, want, got);
        endfunction

        function void check_result(flag_result_t got);
            flag_result_t want;
            string        lane_names[NUM_LANES] = '{"out_w", "out_z", "out_y", "out_x"};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTED)
                    $display("result item with nothing pending: mac %h status %h",
                             got.mac_word, got.status_word);
                return;
            end
            want = pending_results.pop_front();
            for (int p = 0; p < NUM_LANES; p++)
                if (got.lanes[p] !== want.lanes[p])
                    report(lane_names[p], want.lanes[p], got.lanes[p]);
            if (got.mac_word !== want.mac_word)
                report("mac_word", 32'(want.mac_word), 32'(got.mac_word));
            if (got.status_word !== want.status_word)
                report("status_word", 32'(want.status_word), 32'(got.status_word));
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic [LANE_W-1:0] s_lane_x;
    logic [LANE_W-1:0] s_lane_y;
    logic [LANE_W-1:0] s_lane_z;
    logic [LANE_W-1:0] s_lane_w;
    logic [3:0]        s_write_mask;
    logic              s_update_status;
    logic              s_valid;
    logic              s_ready;
    logic [LANE_W-1:0] m_out_x;
    logic [LANE_W-1:0] m_out_y;
    logic [LANE_W-1:0] m_out_z;
    logic [LANE_W-1:0] m_out_w;
    logic [MAC_W-1:0]  m_mac_word;
    logic [STAT_W-1:0] m_status_word;
    logic              m_valid;
    logic              m_ready;

    lane_flag_tracker tracker = new();
    int               send_idle_pct = 22;
    int               recv_idle_pct = 63;
    int               stall_cycles  = 0;

    vector_result_flag_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_lane_x        (s_lane_x),
        .s_lane_y        (s_lane_y),
        .s_lane_z        (s_lane_z),
        .s_lane_w        (s_lane_w),
        .s_write_mask    (s_write_mask),
        .s_update_status (s_update_status),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .m_out_x         (m_out_x),
        .m_out_y         (m_out_y),
        .m_out_z         (m_out_z),
        .m_out_w         (m_out_w),
        .m_mac_word      (m_mac_word),
        .m_status_word   (m_status_word),
        .m_valid         (m_valid),
        .m_ready         (m_ready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial m_ready = 1'b0;

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        flag_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.lanes       = {m_out_x, m_out_y, m_out_z, m_out_w};
            got.mac_word    = m_mac_word;
            got.status_word = m_status_word;
            tracker.check_result(got);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic lane_item_t make_item(logic [LANE_W-1:0] x, logic [LANE_W-1:0] y,
                                             logic [LANE_W-1:0] z, logic [LANE_W-1:0] w,
                                             logic [3:0] mask, logic upd);
        lane_item_t item;
        item.lanes         = {x, y, z, w};
        item.write_mask    = mask;
        item.update_status = upd;
        return item;
    endfunction

    function automatic logic [LANE_W-1:0] random_lane();
        lane_class_t       cls;
        logic [LANE_W-1:0] v;
        cls = ($urandom_range(5) > 3) ? CLS_ANY : lane_class_t'($urandom_range(2));
        v   = $urandom;
        case (cls)
            CLS_ZERO:     v[30:0]  = '0;
            CLS_DENORMAL: begin
                v[30:23] = 8'h00;
                if (v[22:0] == 23'h0)
                    v[0] = 1'b1;
            end
            CLS_SATURATE: v[30:23] = 8'hff;
            default:      ;
        endcase
        return v;
    endfunction

    function automatic lane_item_t random_item();
        return make_item(random_lane(), random_lane(), random_lane(), random_lane(),
                         4'($urandom_range(15)), 1'($urandom_range(1)));
    endfunction

    task automatic send_item(lane_item_t item);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        {s_lane_x, s_lane_y, s_lane_z, s_lane_w} <= item.lanes;
        s_write_mask    <= item.write_mask;
        s_update_status <= item.update_status;
        s_valid         <= 1'b1;
        do
            @(posedge aclk);
        while (!s_ready);
        tracker.note_item(item);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (tracker.pending_results.size() > 0)
            @(negedge aclk);
    endtask

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_lane_x        = '0;
        s_lane_y        = '0;
        s_lane_z        = '0;
        s_lane_w        = '0;
        s_write_mask    = '0;
        s_update_status = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_item(make_item(POS_ZERO, POS_ZERO, POS_ZERO, POS_ZERO, MASK_ALL, 1'b1));
        send_item(make_item(NEG_ZERO, MIN_DENORM, NEG_DENORM, MIN_NORMAL, MASK_ALL, 1'b1));
        send_item(make_item(POS_INF, NEG_INF, QUIET_NAN, ALL_ONES, MASK_ALL, 1'b1));
        send_item(make_item(POS_ONE, LANE_MAX_FINITE, NEG_MAX, NEG_PI, MASK_ALL, 1'b0));
        send_item(make_item(POS_INF, NEG_INF, QUIET_NAN, ALL_ONES, MASK_NONE, 1'b1));
        send_item(make_item(MIN_DENORM, NEG_INF, POS_ZERO, POS_ONE, MASK_X, 1'b1));
        send_item(make_item(MIN_DENORM, NEG_INF, POS_ZERO, POS_ONE, MASK_Y, 1'b1));
        send_item(make_item(MIN_DENORM, NEG_INF, POS_ZERO, POS_ONE, MASK_Z, 1'b1));
        send_item(make_item(MIN_DENORM, NEG_INF, POS_ZERO, POS_ONE, MASK_W, 1'b1));
        send_item(make_item(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, MASK_ALL, 1'b1));
        send_item(make_item(POS_INF, POS_ZERO, NEG_SMALL_DN, NEG_ONE, MASK_XZ, 1'b0));
        send_item(make_item(POS_INF, POS_ZERO, NEG_SMALL_DN, NEG_ONE, MASK_YW, 1'b1));
        send_item(make_item(POS_ZERO, POS_ZERO, POS_ZERO, POS_ZERO, MASK_NONE, 1'b0));
        send_item(make_item(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, MASK_NONE, 1'b1));
        send_item(make_item(NEG_DENORM, MIN_DENORM, NEG_SMALL_DN, MIN_DENORM, MASK_ALL, 1'b1));
        send_item(make_item(NEG_INF, POS_INF, QUIET_NAN, NEG_INF, MASK_ALL, 1'b1));
        send_item(make_item(POS_ZERO, NEG_ZERO, POS_ZERO, NEG_ZERO, MASK_ALL, 1'b1));
        send_item(make_item(POS_ONE, MIN_NORMAL, NEG_PI, LANE_MAX_FINITE, MASK_ALL, 1'b1));

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 22; recv_idle_pct = 63; end
                1: begin send_idle_pct = 63; recv_idle_pct = 22; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(random_item());
            drain_results();
        end

        repeat (10) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
